>>> rtl/tnap_pkg.sv
package tnap_pkg;

   // Working widths of the datapath.
   localparam int CoordW  = 32;
   localparam int PeriodW = 31;
   localparam int MagW    = 63;
   localparam int SumW    = 128;
   localparam int NormW   = 64;
   localparam int QuotW   = 31;
   localparam int AreaW   = 40;
   localparam int AreaShift = 17;

   typedef struct packed {
      logic signed [CoordW-1:0] v0x;
      logic signed [CoordW-1:0] v0y;
      logic signed [CoordW-1:0] v0z;
      logic signed [CoordW-1:0] v1x;
      logic signed [CoordW-1:0] v1y;
      logic signed [CoordW-1:0] v1z;
      logic signed [CoordW-1:0] v2x;
      logic signed [CoordW-1:0] v2y;
      logic signed [CoordW-1:0] v2z;
      logic [2:0]               mirror;
      logic                     reverse;
      logic                     last;
   } tnap_req_type;

   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic neg_z;
      logic degen;
      logic last;
   } tnap_flag_type;

   typedef struct packed {
      logic [MagW-1:0] x;
      logic [MagW-1:0] y;
      logic [MagW-1:0] z;
   } tnap_mag_type;

endpackage

>>> rtl/triangle_normal_area_periodic.sv
// Triangle unit normal and area in a box that is periodic along z.
// Request channel (req_valid / req_ready): one word per triangle, three vertex
// positions in signed Q16.16 plus mirror flags, a reverse flag and a batch mark.
// Response channel (rsp_valid / rsp_ready): one word per triangle, in order:
// the unit normal in signed Q2.30, half the cross product norm in Q24.16
// (saturating), a degenerate flag and the copied batch mark.
// The CSR port writes period_z (csr_we with csr_wdata); write it
// only while no triangle is in flight.
// Throughput is one word per cycle while the output queue has room. There are
// 9 stages for the edges, folding, cross product and squared norm, 64
// stages of the square root (one root bit each) and 31 stages of the
// divider (one quotient bit each).
// Reset clears every valid bit and the output queue and sets period_z to 10.0.
// When the receiver stalls, the two-entry output queue takes the word in flight;
// once it is full the whole pipeline holds and req_ready drops, with nothing
// lost or repeated.
module triangle_normal_area_periodic (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_vertex0_x,
   input  logic signed [31:0]  req_vertex0_y,
   input  logic signed [31:0]  req_vertex0_z,
   input  logic signed [31:0]  req_vertex1_x,
   input  logic signed [31:0]  req_vertex1_y,
   input  logic signed [31:0]  req_vertex1_z,
   input  logic signed [31:0]  req_vertex2_x,
   input  logic signed [31:0]  req_vertex2_y,
   input  logic signed [31:0]  req_vertex2_z,
   input  logic [2:0]          req_mirror_flags,
   input  logic                req_reverse_normal,
   input  logic                req_last_wall,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_normal_x,
   output logic signed [31:0]  rsp_normal_y,
   output logic signed [31:0]  rsp_normal_z,
   output logic [39:0]         rsp_half_area,
   output logic                rsp_degenerate,
   output logic                rsp_last_out,
   input  logic                csr_we,
   input  logic [30:0]         csr_wdata
);
   import tnap_pkg::*;

   localparam logic [PeriodW-1:0] PeriodReset = PeriodW'(655360);
   // Long-box mode when 5 * period exceeds 3.2 in Q16.16 scaled by five.
   localparam logic [PeriodW+2:0] LongThresh = (PeriodW+3)'(16 * 65536);

   typedef struct packed {
      logic signed [CoordW-1:0] nx;
      logic signed [CoordW-1:0] ny;
      logic signed [CoordW-1:0] nz;
      logic [AreaW-1:0]         area;
      logic                     degen;
      logic                     last;
   } rsp_word_type;

   // The period register and its mode bit, computed once at write time.
   logic [PeriodW-1:0] period_ff;
   logic long_ff, long_in;

   assign long_in = ((PeriodW+3)'(csr_wdata) * (PeriodW+3)'(5)) > LongThresh;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PeriodReset;
         long_ff <= 1'b1;
      end else if (csr_we) begin
         period_ff <= csr_wdata;
         long_ff <= long_in;
      end
   end

   // The whole pipeline moves together whenever the output queue has room.
   // The queue is two deep, so a word already in the last stage always fits.
   logic adv;
   logic [1:0] cnt_ff;
   assign adv = (cnt_ff != 2'd2);
   assign req_ready = adv;

   tnap_req_type req;
   assign req.v0x = req_vertex0_x;
   assign req.v0y = req_vertex0_y;
   assign req.v0z = req_vertex0_z;
   assign req.v1x = req_vertex1_x;
   assign req.v1y = req_vertex1_y;
   assign req.v1z = req_vertex1_z;
   assign req.v2x = req_vertex2_x;
   assign req.v2y = req_vertex2_y;
   assign req.v2z = req_vertex2_z;
   assign req.mirror  = req_mirror_flags;
   assign req.reverse = req_reverse_normal;
   assign req.last    = req_last_wall;

   logic            fr_valid;
   logic [SumW-1:0] fr_sum;
   tnap_mag_type    fr_mag;
   tnap_flag_type   fr_flag;

   tnap_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_req    (req),
      .period    (period_ff),
      .long_box  (long_ff),
      .out_valid (fr_valid),
      .out_sum   (fr_sum),
      .out_mag   (fr_mag),
      .out_flag  (fr_flag)
   );

   logic             sq_valid;
   logic [NormW-1:0] sq_norm;
   tnap_mag_type     sq_mag;
   tnap_flag_type    sq_flag;

   tnap_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_sum    (fr_sum),
      .in_mag    (fr_mag),
      .in_flag   (fr_flag),
      .out_valid (sq_valid),
      .out_norm  (sq_norm),
      .out_mag   (sq_mag),
      .out_flag  (sq_flag)
   );

   logic             dv_valid;
   logic [NormW-1:0] dv_norm;
   logic [QuotW-1:0] dv_qx, dv_qy, dv_qz;
   tnap_flag_type    dv_flag;

   tnap_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_norm   (sq_norm),
      .in_mag    (sq_mag),
      .in_flag   (sq_flag),
      .out_valid (dv_valid),
      .out_norm  (dv_norm),
      .out_qx    (dv_qx),
      .out_qy    (dv_qy),
      .out_qz    (dv_qz),
      .out_flag  (dv_flag)
   );

   // Sign the quotients, saturate the area and force a degenerate word to zero.
   localparam int AreaFullW = NormW - AreaShift;
   rsp_word_type fmt;
   logic signed [CoordW-1:0] qx_s, qy_s, qz_s;
   logic [AreaFullW-1:0] area_full;

   always_comb begin
      qx_s = $signed({{(CoordW-QuotW){1'b0}}, dv_qx});
      qy_s = $signed({{(CoordW-QuotW){1'b0}}, dv_qy});
      qz_s = $signed({{(CoordW-QuotW){1'b0}}, dv_qz});
      area_full = dv_norm[NormW-1:AreaShift];
      if (dv_flag.degen) begin
         fmt.nx = '0;
         fmt.ny = '0;
         fmt.nz = '0;
         fmt.area = '0;
      end else begin
         fmt.nx = dv_flag.neg_x ? -qx_s : qx_s;
         fmt.ny = dv_flag.neg_y ? -qy_s : qy_s;
         fmt.nz = dv_flag.neg_z ? -qz_s : qz_s;
         fmt.area = (|area_full[AreaFullW-1:AreaW]) ? {AreaW{1'b1}}
                                                   : area_full[AreaW-1:0];
      end
      fmt.degen = dv_flag.degen;
      fmt.last  = dv_flag.last;
   end

   // Two-entry output queue.
   rsp_word_type q_ff [2];
   logic wr_ff, rd_ff;
   logic push, pop;

   assign push = adv && dv_valid;
   assign pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         if (push && !pop) cnt_ff <= cnt_ff + 2'd1;
         else if (pop && !push) cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= fmt;
   end

   rsp_word_type head;
   assign head = q_ff[rd_ff];

   assign rsp_valid      = (cnt_ff != 2'd0);
   assign rsp_normal_x   = head.nx;
   assign rsp_normal_y   = head.ny;
   assign rsp_normal_z   = head.nz;
   assign rsp_half_area  = head.area;
   assign rsp_degenerate = head.degen;
   assign rsp_last_out   = head.last;

   // The queue never holds more than two words.
   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("output queue overflow");

   // A full queue with a stalled receiver holds the request side.
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !rsp_ready) |=> !req_ready)
      else $error("request accepted while output queue full");

   // A degenerate word carries a zero normal and zero area.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
      (rsp_normal_x == 0 && rsp_normal_y == 0 && rsp_normal_z == 0 && rsp_half_area == 0))
      else $error("degenerate word with nonzero payload");

   // The x and z normal parts stay within one in Q2.30.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
      (rsp_normal_x <= 32'sd1073741824 && rsp_normal_x >= -32'sd1073741824 &&
       rsp_normal_z <= 32'sd1073741824 && rsp_normal_z >= -32'sd1073741824))
      else $error("normal part out of range");

endmodule

>>> rtl/tnap_front.sv
module tnap_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  tnap_pkg::tnap_req_type        in_req,
   input  logic [tnap_pkg::PeriodW-1:0]  period,
   input  logic                          long_box,
   output logic                          out_valid,
   output logic [tnap_pkg::SumW-1:0]     out_sum,
   output tnap_pkg::tnap_mag_type        out_mag,
   output tnap_pkg::tnap_flag_type       out_flag
);
   import tnap_pkg::*;

   localparam int ZW = 40;
   localparam int EW = CoordW + 1;
   localparam int PW = 2 * CoordW;
   localparam int NumStages = 9;
   localparam logic signed [ZW-1:0] EdgeHi = ZW'(64'sd2147483647);
   localparam logic signed [ZW-1:0] EdgeLo = -EdgeHi;

   function automatic logic signed [ZW-1:0] fold_z(input logic signed [ZW-1:0] z,
                                                   input logic signed [ZW-1:0] p,
                                                   input logic lb);
      logic signed [ZW-1:0] t;
      t = z;
      if (lb) begin
         if ((t <<< 1) > p) t = t - p;
         if ((t <<< 1) < -p) t = t + p;
      end else begin
         if ((t + (t <<< 1)) > (p <<< 1)) t = t - p;
         if ((t + (t <<< 1)) < -(p <<< 1)) t = t + p;
      end
      return t;
   endfunction

   function automatic logic signed [CoordW-1:0] clamp_edge(input logic signed [ZW-1:0] v);
      if (v > EdgeHi) return EdgeHi[CoordW-1:0];
      else if (v < EdgeLo) return EdgeLo[CoordW-1:0];
      else return v[CoordW-1:0];
   endfunction

   logic [NumStages-1:0] vld_ff;
   logic signed [ZW-1:0] p_s;
   assign p_s = $signed({{(ZW-PeriodW){1'b0}}, period});

   // Stage 1: edge vectors from the apex vertex.
   logic signed [EW-1:0] s1_e1x_ff, s1_e1y_ff, s1_e1z_ff, s1_e2x_ff, s1_e2y_ff, s1_e2z_ff;
   logic [2:0] s1_mirror_ff;
   logic s1_rev_ff, s1_last_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_e1x_ff <= EW'(in_req.v1x) - EW'(in_req.v0x);
         s1_e1y_ff <= EW'(in_req.v1y) - EW'(in_req.v0y);
         s1_e1z_ff <= EW'(in_req.v1z) - EW'(in_req.v0z);
         s1_e2x_ff <= EW'(in_req.v2x) - EW'(in_req.v0x);
         s1_e2y_ff <= EW'(in_req.v2y) - EW'(in_req.v0y);
         s1_e2z_ff <= EW'(in_req.v2z) - EW'(in_req.v0z);
         s1_mirror_ff <= in_req.mirror;
         s1_rev_ff <= in_req.reverse;
         s1_last_ff <= in_req.last;
      end
   end

   // Stage 2: fold z into the box, then apply the mirror signs in short-box mode.
   logic signed [ZW-1:0] s2_e1z_in, s2_e2z_in, f1, f2;
   logic signed [EW-1:0] s2_e1x_ff, s2_e1y_ff, s2_e2x_ff, s2_e2y_ff;
   logic signed [ZW-1:0] s2_e1z_ff, s2_e2z_ff;
   logic s2_rev_ff, s2_last_ff;

   always_comb begin
      f1 = fold_z(ZW'(s1_e1z_ff), p_s, long_box);
      f2 = fold_z(ZW'(s1_e2z_ff), p_s, long_box);
      s2_e1z_in = f1;
      s2_e2z_in = f2;
      if (!long_box) begin
         if (s1_mirror_ff[1]) s2_e1z_in = -f1;
         if (s1_mirror_ff[2] ^ s1_mirror_ff[0]) s2_e2z_in = -f2;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_e1x_ff <= s1_e1x_ff;
         s2_e1y_ff <= s1_e1y_ff;
         s2_e2x_ff <= s1_e2x_ff;
         s2_e2y_ff <= s1_e2y_ff;
         s2_e1z_ff <= s2_e1z_in;
         s2_e2z_ff <= s2_e2z_in;
         s2_rev_ff <= s1_rev_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // Stage 3: the retry edge moved by one period, and clamping of every part.
   logic signed [ZW-1:0] s3_rz_in;
   logic signed [CoordW-1:0] s3_a0_ff, s3_a1_ff, s3_a2_ff, s3_ra2_ff;
   logic signed [CoordW-1:0] s3_b0_ff, s3_b1_ff, s3_b2_ff;
   logic s3_rev_ff, s3_last_ff;

   assign s3_rz_in = (s2_e1z_ff > 0) ? s2_e1z_ff - p_s : s2_e1z_ff + p_s;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_a0_ff  <= clamp_edge(ZW'(s2_e1x_ff));
         s3_a1_ff  <= clamp_edge(ZW'(s2_e1y_ff));
         s3_a2_ff  <= clamp_edge(s2_e1z_ff);
         s3_ra2_ff <= clamp_edge(s3_rz_in);
         s3_b0_ff  <= clamp_edge(ZW'(s2_e2x_ff));
         s3_b1_ff  <= clamp_edge(ZW'(s2_e2y_ff));
         s3_b2_ff  <= clamp_edge(s2_e2z_ff);
         s3_rev_ff <= s2_rev_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

   // Stage 4: partial products of both cross products.
   logic signed [PW-1:0] s4_a1b2_ff, s4_a2b1_ff, s4_ra2b1_ff, s4_a2b0_ff;
   logic signed [PW-1:0] s4_ra2b0_ff, s4_a0b2_ff, s4_a0b1_ff, s4_a1b0_ff;
   logic s4_rev_ff, s4_last_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_a1b2_ff  <= PW'(s3_a1_ff) * PW'(s3_b2_ff);
         s4_a2b1_ff  <= PW'(s3_a2_ff) * PW'(s3_b1_ff);
         s4_ra2b1_ff <= PW'(s3_ra2_ff) * PW'(s3_b1_ff);
         s4_a2b0_ff  <= PW'(s3_a2_ff) * PW'(s3_b0_ff);
         s4_ra2b0_ff <= PW'(s3_ra2_ff) * PW'(s3_b0_ff);
         s4_a0b2_ff  <= PW'(s3_a0_ff) * PW'(s3_b2_ff);
         s4_a0b1_ff  <= PW'(s3_a0_ff) * PW'(s3_b1_ff);
         s4_a1b0_ff  <= PW'(s3_a1_ff) * PW'(s3_b0_ff);
         s4_rev_ff <= s3_rev_ff;
         s4_last_ff <= s3_last_ff;
      end
   end

   // Stage 5: cross product parts, plain and retried.
   logic signed [PW-1:0] s5_c0_ff, s5_c1_ff, s5_c2_ff, s5_rc0_ff, s5_rc1_ff;
   logic s5_rev_ff, s5_last_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_c0_ff  <= s4_a1b2_ff - s4_a2b1_ff;
         s5_rc0_ff <= s4_a1b2_ff - s4_ra2b1_ff;
         s5_c1_ff  <= s4_a2b0_ff - s4_a0b2_ff;
         s5_rc1_ff <= s4_ra2b0_ff - s4_a0b2_ff;
         s5_c2_ff  <= s4_a0b1_ff - s4_a1b0_ff;
         s5_rev_ff <= s4_rev_ff;
         s5_last_ff <= s4_last_ff;
      end
   end

   // Stage 6: choose the retry when the first cross product is zero, split sign and size.
   logic s6_zero, s6_retry_zero;
   logic signed [PW-1:0] s6_x, s6_y;
   tnap_mag_type s6_mag_in, s6_mag_ff;
   tnap_flag_type s6_flag_in, s6_flag_ff;

   always_comb begin
      s6_zero = (s5_c0_ff == 0) && (s5_c1_ff == 0) && (s5_c2_ff == 0);
      s6_retry_zero = (s5_rc0_ff == 0) && (s5_rc1_ff == 0) && (s5_c2_ff == 0);
      s6_x = s6_zero ? s5_rc0_ff : s5_c0_ff;
      s6_y = s6_zero ? s5_rc1_ff : s5_c1_ff;
      s6_mag_in.x = s6_x[PW-1] ? MagW'(-s6_x) : MagW'(s6_x);
      s6_mag_in.y = s6_y[PW-1] ? MagW'(-s6_y) : MagW'(s6_y);
      s6_mag_in.z = s5_c2_ff[PW-1] ? MagW'(-s5_c2_ff) : MagW'(s5_c2_ff);
      s6_flag_in.neg_x = s6_x[PW-1] ^ s5_rev_ff;
      s6_flag_in.neg_y = s6_y[PW-1] ^ s5_rev_ff;
      s6_flag_in.neg_z = s5_c2_ff[PW-1] ^ s5_rev_ff;
      s6_flag_in.degen = s6_zero && s6_retry_zero;
      s6_flag_in.last  = s5_last_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_mag_ff <= s6_mag_in;
         s6_flag_ff <= s6_flag_in;
      end
   end

   // Stage 7: squares in 32-bit halves.
   localparam int HiW = MagW - 32;
   logic [2*HiW-1:0]   s7_hh_ff [3];
   logic [HiW+31:0]    s7_hl_ff [3];
   logic [63:0]        s7_ll_ff [3];
   logic [MagW-1:0]    s7_m [3];
   tnap_mag_type s7_mag_ff;
   tnap_flag_type s7_flag_ff;

   assign s7_m[0] = s6_mag_ff.x;
   assign s7_m[1] = s6_mag_ff.y;
   assign s7_m[2] = s6_mag_ff.z;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            s7_hh_ff[j] <= (2*HiW)'(s7_m[j][MagW-1:32]) * (2*HiW)'(s7_m[j][MagW-1:32]);
            s7_hl_ff[j] <= (HiW+32)'(s7_m[j][MagW-1:32]) * (HiW+32)'(s7_m[j][31:0]);
            s7_ll_ff[j] <= 64'(s7_m[j][31:0]) * 64'(s7_m[j][31:0]);
         end
         s7_mag_ff <= s6_mag_ff;
         s7_flag_ff <= s6_flag_ff;
      end
   end

   // Stage 8: square of each part.
   logic [SumW-1:0] s8_sq_ff [3];
   tnap_mag_type s8_mag_ff;
   tnap_flag_type s8_flag_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            s8_sq_ff[j] <= (SumW'(s7_hh_ff[j]) << 64) + (SumW'(s7_hl_ff[j]) << 33)
                           + SumW'(s7_ll_ff[j]);
         end
         s8_mag_ff <= s7_mag_ff;
         s8_flag_ff <= s7_flag_ff;
      end
   end

   // Stage 9: squared norm.
   logic [SumW-1:0] s9_sum_ff;
   tnap_mag_type s9_mag_ff;
   tnap_flag_type s9_flag_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s9_sum_ff <= s8_sq_ff[0] + s8_sq_ff[1] + s8_sq_ff[2];
         s9_mag_ff <= s8_mag_ff;
         s9_flag_ff <= s8_flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NumStages-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[NumStages-1];
   assign out_sum   = s9_sum_ff;
   assign out_mag   = s9_mag_ff;
   assign out_flag  = s9_flag_ff;

endmodule

>>> rtl/tnap_sqrt.sv
module tnap_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [tnap_pkg::SumW-1:0]     in_sum,
   input  tnap_pkg::tnap_mag_type        in_mag,
   input  tnap_pkg::tnap_flag_type       in_flag,
   output logic                          out_valid,
   output logic [tnap_pkg::NormW-1:0]    out_norm,
   output tnap_pkg::tnap_mag_type        out_mag,
   output tnap_pkg::tnap_flag_type       out_flag
);
   import tnap_pkg::*;

   // One root bit per stage, two radicand bits brought down each time.
   localparam int Steps = NormW;
   localparam int RemW  = NormW + 3;

   logic            vld_ff  [Steps];
   logic [NormW-1:0] root_ff [Steps];
   logic [RemW-1:0] rem_ff  [Steps-1];
   logic [SumW-1:0] rad_ff  [Steps-1];
   tnap_mag_type    mag_ff  [Steps];
   tnap_flag_type   flag_ff [Steps];

   for (genvar k = 0; k < Steps; k++) begin : g_step
      logic            cur_vld;
      logic [NormW-1:0] cur_root;
      logic [RemW-1:0] cur_rem;
      logic [SumW-1:0] cur_rad;
      tnap_mag_type    cur_mag;
      tnap_flag_type   cur_flag;
      logic [RemW-1:0] sh;
      logic [RemW-1:0] trial;
      logic            take;

      if (k == 0) begin : g_first
         assign cur_vld  = in_valid;
         assign cur_root = '0;
         assign cur_rem  = '0;
         assign cur_rad  = in_sum;
         assign cur_mag  = in_mag;
         assign cur_flag = in_flag;
      end else begin : g_next
         assign cur_vld  = vld_ff[k-1];
         assign cur_root = root_ff[k-1];
         assign cur_rem  = rem_ff[k-1];
         assign cur_rad  = rad_ff[k-1];
         assign cur_mag  = mag_ff[k-1];
         assign cur_flag = flag_ff[k-1];
      end

      assign sh    = {cur_rem[RemW-3:0], cur_rad[SumW-1-2*k -: 2]};
      assign trial = {{(RemW-NormW-2){1'b0}}, cur_root, 2'b01};
      assign take  = (sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= cur_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            root_ff[k] <= {cur_root[NormW-2:0], take};
            mag_ff[k]  <= cur_mag;
            flag_ff[k] <= cur_flag;
         end
      end

      if (k < Steps - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k] <= take ? sh - trial : sh;
               rad_ff[k] <= cur_rad;
            end
         end
      end
   end

   assign out_valid = vld_ff[Steps-1];
   assign out_norm  = root_ff[Steps-1];
   assign out_mag   = mag_ff[Steps-1];
   assign out_flag  = flag_ff[Steps-1];

endmodule

>>> rtl/tnap_div.sv
module tnap_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [tnap_pkg::NormW-1:0]    in_norm,
   input  tnap_pkg::tnap_mag_type        in_mag,
   input  tnap_pkg::tnap_flag_type       in_flag,
   output logic                          out_valid,
   output logic [tnap_pkg::NormW-1:0]    out_norm,
   output logic [tnap_pkg::QuotW-1:0]    out_qx,
   output logic [tnap_pkg::QuotW-1:0]    out_qy,
   output logic [tnap_pkg::QuotW-1:0]    out_qz,
   output tnap_pkg::tnap_flag_type       out_flag
);
   import tnap_pkg::*;

   // Restoring division, one quotient bit per stage, three lanes side by side.
   localparam int Steps = QuotW;
   localparam int RemW  = NormW + 1;

   logic [MagW-1:0] in_m [3];
   assign in_m[0] = in_mag.x;
   assign in_m[1] = in_mag.y;
   assign in_m[2] = in_mag.z;

   logic             vld_ff  [Steps];
   logic [NormW-1:0] d_ff    [Steps];
   tnap_flag_type    flag_ff [Steps];
   logic [QuotW-1:0] q_ff    [Steps][3];
   logic [NormW-1:0] rem_ff  [Steps-1][3];

   for (genvar k = 0; k < Steps; k++) begin : g_step
      logic             cur_vld;
      logic [NormW-1:0] cur_d;
      tnap_flag_type    cur_flag;
      logic [RemW-1:0]  r     [3];
      logic [RemW-1:0]  diff  [3];
      logic             ge    [3];
      logic [QuotW-1:0] cur_q [3];

      if (k == 0) begin : g_first
         assign cur_vld  = in_valid;
         assign cur_d    = in_norm;
         assign cur_flag = in_flag;
         for (genvar j = 0; j < 3; j++) begin : g_lane
            assign r[j]     = {{(RemW-MagW){1'b0}}, in_m[j]};
            assign cur_q[j] = '0;
         end
      end else begin : g_next
         assign cur_vld  = vld_ff[k-1];
         assign cur_d    = d_ff[k-1];
         assign cur_flag = flag_ff[k-1];
         for (genvar j = 0; j < 3; j++) begin : g_lane
            assign r[j]     = {rem_ff[k-1][j], 1'b0};
            assign cur_q[j] = q_ff[k-1][j];
         end
      end

      for (genvar j = 0; j < 3; j++) begin : g_cmp
         assign diff[j] = r[j] - {1'b0, cur_d};
         assign ge[j]   = (r[j] >= {1'b0, cur_d});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= cur_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            d_ff[k]    <= cur_d;
            flag_ff[k] <= cur_flag;
            for (int j = 0; j < 3; j++) begin
               q_ff[k][j] <= {cur_q[j][QuotW-2:0], ge[j]};
            end
         end
      end

      if (k < Steps - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (adv) begin
               for (int j = 0; j < 3; j++) begin
                  rem_ff[k][j] <= ge[j] ? diff[j][NormW-1:0] : r[j][NormW-1:0];
               end
            end
         end
      end
   end

   assign out_valid = vld_ff[Steps-1];
   assign out_norm  = d_ff[Steps-1];
   assign out_qx    = q_ff[Steps-1][0];
   assign out_qy    = q_ff[Steps-1][1];
   assign out_qz    = q_ff[Steps-1][2];
   assign out_flag  = flag_ff[Steps-1];

endmodule
